// ===== src/mf2d_pkg.sv =====
// Shared types, constants and helpers of the 2-D median filter.
`timescale 1ns / 1ps

package mf2d_pkg;

  localparam int MaxWindow  = 7;
  localparam int MaxCols    = 1024;
  localparam int PixBits    = 8;
  localparam int ColBits    = 10;
  localparam int ColCntBits = 11;
  localparam int RowCntBits = 13;
  localparam int MaxRows    = 4096;
  localparam int WinBits    = 3;
  localparam int CfgBits    = 13;
  localparam int OutRowBits = 12;
  localparam int PosBits    = 23;
  localparam int WinElems   = MaxWindow * MaxWindow;
  localparam int RankBits   = 6;
  localparam int ModBits    = 3;
  localparam int Phantoms   = MaxWindow - 1;
  localparam int FifoDepth  = 16;
  localparam int FifoPtrBits = 4;

  typedef logic [PixBits-1:0] pix_t;

  typedef enum logic [1:0] {
    CfgWindow = 2'd0,
    CfgCols   = 2'd1,
    CfgRows   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    pix_t                  value;
    logic [OutRowBits-1:0] row;
    logic [ColBits-1:0]    col;
    logic                  last;
  } res_t;

  // Rank of the lower middle element of a w x w window.
  function automatic logic [RankBits-1:0] median_rank(input logic [WinBits-1:0] w);
    logic [RankBits:0] sq;
    sq = (RankBits+1)'(w) * (RankBits+1)'(w);
    return RankBits'((sq - (RankBits+1)'(1)) >> 1);
  endfunction

endpackage

// ===== src/mf2d_if.sv =====
// Stream channel interfaces of the 2-D median filter (pixel in, result out).
`timescale 1ns / 1ps

interface mf2d_pix_if;
  logic              valid;
  logic              ready;
  mf2d_pkg::pix_t    pixel;
  logic              frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mf2d_res_if;
  logic                                valid;
  logic                                ready;
  mf2d_pkg::pix_t                      value;
  logic [mf2d_pkg::OutRowBits-1:0]     out_row;
  logic [mf2d_pkg::ColBits-1:0]        out_col;
  logic                                last;

  modport source (output valid, value, out_row, out_col, last, input ready);
  modport sink   (input valid, value, out_row, out_col, last, output ready);
endinterface

// ===== src/median_filter_2d_core.sv =====
// Top level of the streaming 2-D median filter with a square window.
// Throughput: one pixel request per cycle when running and a result FIFO slot is free; the
// FIFO decouples backpressure. A result passes stage 1, the rank-selection stages and the FIFO.
// Reset: a clearing pass zeroes all 1024 columns of the line store, all 7 banks at once; ready low.
// A configuration write stalls input through a 23-step position division and 6 column refills.
`timescale 1ns / 1ps

module median_filter_2d_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [mf2d_pkg::CfgBits-1:0] cfg_data_i,
  mf2d_pix_if.sink                     pix_i,
  mf2d_res_if.source                   res_o
);
  import mf2d_pkg::*;

  typedef enum logic [1:0] {StClear, StDiv, StRefill, StRun} seq_e;

  typedef struct packed {
    logic                  inner;
    logic [OutRowBits-1:0] row;
    logic [ColBits-1:0]    col;
    logic                  last;
  } meta_t;

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam pix_t White = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers and their clamped values
  // ---------------------------------------------------------------------------
  logic [WinBits-1:0]    win_q;
  logic [ColCntBits-1:0] cols_q;
  logic [RowCntBits-1:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WinBits'(3);
      cols_q <= ColCntBits'(640);
      rows_q <= RowCntBits'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWindow: win_q  <= cfg_data_i[WinBits-1:0];
        CfgCols:   cols_q <= cfg_data_i[ColCntBits-1:0];
        CfgRows:   rows_q <= cfg_data_i[RowCntBits-1:0];
        default: ;
      endcase
    end
  end

  logic [WinBits-1:0]    w_eff, n1, after;
  logic [ColCntBits-1:0] cols_eff;
  logic [RowCntBits-1:0] rows_eff;

  always_comb begin
    w_eff    = (win_q == '0) ? WinBits'(1) : win_q;
    n1       = (w_eff - WinBits'(1)) >> 1;
    after    = w_eff >> 1;
    cols_eff = (cols_q == '0) ? ColCntBits'(1) :
               (cols_q > ColCntBits'(MaxCols)) ? ColCntBits'(MaxCols) : cols_q;
    rows_eff = (rows_q == '0) ? RowCntBits'(1) :
               (rows_q > RowCntBits'(MaxRows)) ? RowCntBits'(MaxRows) : rows_q;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clear pass, position re-division after config, column refill
  // ---------------------------------------------------------------------------
  seq_e                  state_q;
  logic [ColBits-1:0]    seq_q;
  logic                  pend_q;
  logic [PosBits-1:0]    pos_q, prow_q;
  logic [ColBits-1:0]    pcol_q;
  logic [ModBits-1:0]    pmod_q;
  logic [ColCntBits-1:0] div_rem_q;
  logic [PosBits-1:0]    div_quo_q;
  logic [ModBits-1:0]    div_mod_q;

  logic                  acc;
  logic [FifoPtrBits:0]  resv_q;

  assign pix_i.ready = (state_q == StRun) && (resv_q < (FifoPtrBits+1)'(FifoDepth));
  assign acc = pix_i.valid && pix_i.ready;

  // Restoring divider step: one quotient bit per cycle, MSB first; the row
  // index modulo the bank count is folded in as quotient bits arrive.
  logic [4:0]            div_bit_idx;
  logic [ColCntBits:0]   rem_sh;
  logic                  div_ge;
  logic [ColCntBits-1:0] rem_nx;
  logic [PosBits-1:0]    quo_nx;
  logic [ModBits:0]      mod2;
  logic [ModBits-1:0]    mod_nx;

  always_comb begin
    div_bit_idx = 5'(PosBits-1) - seq_q[4:0];
    rem_sh      = {div_rem_q, pos_q[div_bit_idx]};
    div_ge      = rem_sh >= {1'b0, cols_eff};
    rem_nx      = div_ge ? ColCntBits'(rem_sh - {1'b0, cols_eff}) : ColCntBits'(rem_sh);
    quo_nx      = {div_quo_q[PosBits-2:0], div_ge};
    mod2        = {div_mod_q, div_ge};
    mod_nx      = (mod2 >= (ModBits+1)'(MaxWindow)) ? ModBits'(mod2 - (ModBits+1)'(MaxWindow))
                                                     : ModBits'(mod2);
  end

  // Position of the accepted request (frame start forces position zero).
  logic [PosBits-1:0] cur_pos, cur_row, nxt_pos, nxt_row;
  logic [ColBits-1:0] cur_col, nxt_col;
  logic [ModBits-1:0] cur_mod, nxt_mod;

  always_comb begin
    if (pix_i.frame_start) begin
      cur_pos = '0;
      cur_row = '0;
      cur_col = '0;
      cur_mod = '0;
    end else begin
      cur_pos = pos_q;
      cur_row = prow_q;
      cur_col = pcol_q;
      cur_mod = pmod_q;
    end
    nxt_pos = cur_pos;
    nxt_row = cur_row;
    nxt_col = cur_col;
    nxt_mod = cur_mod;
    if (cur_pos != PosMax) begin
      nxt_pos = cur_pos + PosBits'(1);
      if ({1'b0, cur_col} + ColCntBits'(1) == cols_eff) begin
        nxt_col = '0;
        nxt_row = cur_row + PosBits'(1);
        nxt_mod = (cur_mod == ModBits'(MaxWindow-1)) ? '0 : cur_mod + ModBits'(1);
      end else begin
        nxt_col = cur_col + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      seq_q     <= '0;
      pend_q    <= 1'b0;
      pos_q     <= '0;
      prow_q    <= '0;
      pcol_q    <= '0;
      pmod_q    <= '0;
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_mod_q <= '0;
    end else begin
      unique case (state_q)
        StClear: begin
          if (seq_q == ColBits'(MaxCols-1)) begin
            seq_q     <= '0;
            pend_q    <= 1'b0;
            state_q   <= (pend_q || cfg_we_i) ? StDiv : StRun;
            div_rem_q <= '0;
            div_quo_q <= '0;
            div_mod_q <= '0;
          end else begin
            seq_q <= seq_q + ColBits'(1);
            if (cfg_we_i) pend_q <= 1'b1;
          end
        end
        StDiv: begin
          if (cfg_we_i) begin
            // restart with the new geometry
            seq_q     <= '0;
            div_rem_q <= '0;
            div_quo_q <= '0;
            div_mod_q <= '0;
          end else begin
            div_rem_q <= rem_nx;
            div_quo_q <= quo_nx;
            div_mod_q <= mod_nx;
            if (seq_q == ColBits'(PosBits-1)) begin
              seq_q   <= '0;
              state_q <= StRefill;
              prow_q  <= quo_nx;
              pcol_q  <= rem_nx[ColBits-1:0];
              pmod_q  <= mod_nx;
            end else begin
              seq_q <= seq_q + ColBits'(1);
            end
          end
        end
        StRefill, StRun: begin
          if (cfg_we_i) begin
            state_q   <= StDiv;
            seq_q     <= '0;
            div_rem_q <= '0;
            div_quo_q <= '0;
            div_mod_q <= '0;
          end else if (state_q == StRefill) begin
            if (seq_q == ColBits'(Phantoms-1)) begin
              seq_q   <= '0;
              state_q <= StRun;
            end else begin
              seq_q <= seq_q + ColBits'(1);
            end
          end else if (acc) begin
            pos_q  <= nxt_pos;
            prow_q <= nxt_row;
            pcol_q <= nxt_col;
            pmod_q <= nxt_mod;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode: store write, output position, border test
  // ---------------------------------------------------------------------------
  logic                  clearing, ph_vld, wr_en;
  logic [ModBits-1:0]    ph_k;
  logic [ColBits-1:0]    ph_col, rd_addr;
  logic [ColCntBits-1:0] oc_w;
  logic [ColCntBits:0]   oc_t;
  logic [1:0]            nb;
  logic [PosBits:0]      orow_x;
  logic [PosBits-1:0]    orow;
  logic                  out_vld, inner, last;
  logic [ModBits:0]      rot_w;
  logic [ModBits-1:0]    rot, rd_mod;

  always_comb begin
    clearing = (state_q == StClear);
    ph_vld   = (state_q == StRefill) && !cfg_we_i;
    ph_k     = ModBits'(Phantoms) - seq_q[ModBits-1:0];
    ph_col   = (pcol_q >= ColBits'(ph_k)) ? pcol_q - ColBits'(ph_k) : '0;
    rd_addr  = acc ? cur_col : ph_col;
    rd_mod   = acc ? cur_mod : pmod_q;
    wr_en    = acc && (cur_row < PosBits'(rows_eff));

    // output position = request position - (w/2)*(cols+1); rows narrower
    // than w/2 borrow from the row count more than once
    oc_t = {2'b00, cur_col} - (ColCntBits+1)'(after);
    nb   = '0;
    for (int k = 0; k < MaxWindow/2; k++) begin
      if (oc_t[ColCntBits]) begin
        oc_t = oc_t + {1'b0, cols_eff};
        nb   = nb + 2'd1;
      end
    end
    oc_w   = oc_t[ColCntBits-1:0];
    orow_x = {1'b0, cur_row} - (PosBits+1)'(after) - (PosBits+1)'(nb);
    orow   = orow_x[PosBits-1:0];
    out_vld = !orow_x[PosBits] && (orow < PosBits'(rows_eff));
    inner   = (orow >= PosBits'(n1))
           && ({1'b0, orow} + (PosBits+1)'(after) < (PosBits+1)'(rows_eff))
           && (oc_w >= ColCntBits'(n1))
           && (oc_w + ColCntBits'(after) < cols_eff);
    last    = (orow == PosBits'(rows_eff) - PosBits'(1))
           && (oc_w == cols_eff - ColCntBits'(1));

    // bank holding the top row of the column read
    rot_w = (ModBits+1)'(rd_mod) + (ModBits+1)'(MaxWindow+1) - (ModBits+1)'(w_eff);
    rot   = (rot_w >= (ModBits+1)'(MaxWindow)) ? ModBits'(rot_w - (ModBits+1)'(MaxWindow))
                                               : ModBits'(rot_w);
  end

  // ---------------------------------------------------------------------------
  // Line store: one bank per row modulo the maximum window height, read at one column
  // ---------------------------------------------------------------------------
  pix_t lstore_mem [MaxWindow][MaxCols];
  pix_t rd_q [MaxWindow];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < MaxWindow; b++) begin
      if (clearing) begin
        lstore_mem[b][seq_q] <= '0;
      end else if (wr_en && (cur_mod == ModBits'(b))) begin
        lstore_mem[b][cur_col] <= pix_i.pixel;
      end
      rd_q[b] <= lstore_mem[b][rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: forward the pixel written this cycle, rotate banks into a column
  // ---------------------------------------------------------------------------
  logic               s1_vld_q, s1_out_q;
  meta_t              s1_meta_q;
  logic [ModBits-1:0] s1_rot_q, s1_fbank_q;
  logic               s1_fwd_q;
  pix_t               s1_fpix_q;
  logic [WinBits-1:0] s1_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_out_q <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else begin
      s1_vld_q <= acc || ph_vld;
      s1_out_q <= acc && out_vld;
      s1_fwd_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_meta_q  <= '{inner: inner, row: orow[OutRowBits-1:0], col: oc_w[ColBits-1:0],
                    last: last};
    s1_rot_q   <= rot;
    s1_fbank_q <= cur_mod;
    s1_fpix_q  <= pix_i.pixel;
    s1_w_q     <= w_eff;
  end

  pix_t                bank_rd [MaxWindow];
  pix_t                colv [MaxWindow];
  pix_t                hist_q [MaxWindow-1][MaxWindow];
  pix_t                win [WinElems];
  logic [WinElems-1:0] win_msk;
  logic [ModBits:0]    cidx;

  always_comb begin
    cidx = '0;
    for (int b = 0; b < MaxWindow; b++) begin
      bank_rd[b] = (s1_fwd_q && (s1_fbank_q == ModBits'(b))) ? s1_fpix_q : rd_q[b];
    end
    for (int i = 0; i < MaxWindow; i++) begin
      cidx = (ModBits+1)'(s1_rot_q) + (ModBits+1)'(i);
      if (cidx >= (ModBits+1)'(MaxWindow)) cidx = cidx - (ModBits+1)'(MaxWindow);
      colv[i] = bank_rd[cidx[ModBits-1:0]];
    end
    // column 0 is the newest
    for (int j = 0; j < MaxWindow; j++) begin
      for (int i = 0; i < MaxWindow; i++) begin
        win[j*MaxWindow+i]     = (j == 0) ? colv[i] : hist_q[(j == 0) ? 0 : j-1][i];
        win_msk[j*MaxWindow+i] = (WinBits'(i) < s1_w_q) && (WinBits'(j) < s1_w_q);
      end
    end
  end

  // shift every column read (requests and refills) into the history
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      hist_q[0] <= colv;
      for (int j = 1; j < MaxWindow-1; j++) hist_q[j] <= hist_q[j-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Rank selection: one result bit per stage, MSB first
  // ---------------------------------------------------------------------------
  logic                st_vld_q  [PixBits];
  pix_t                st_val_q  [PixBits][WinElems];
  logic [WinElems-1:0] st_msk_q  [PixBits];
  logic [RankBits-1:0] st_rank_q [PixBits];
  pix_t                st_res_q  [PixBits];
  meta_t               st_meta_q [PixBits];

  logic [WinElems-1:0] st_pl   [PixBits];
  logic [WinElems-1:0] st_zero [PixBits];
  logic [RankBits-1:0] st_cnt  [PixBits];
  logic                st_one  [PixBits];
  logic [WinElems-1:0] nx_msk  [PixBits];
  logic [RankBits-1:0] nx_rank [PixBits];
  pix_t                nx_res  [PixBits];

  always_comb begin
    for (int s = 0; s < PixBits; s++) begin
      for (int e = 0; e < WinElems; e++) st_pl[s][e] = st_val_q[s][e][PixBits-1-s];
      st_zero[s] = st_msk_q[s] & ~st_pl[s];
      st_cnt[s]  = RankBits'($countones(st_zero[s]));
      st_one[s]  = st_rank_q[s] >= st_cnt[s];
      nx_res[s]  = st_res_q[s];
      nx_res[s][PixBits-1-s] = st_one[s];
      nx_msk[s]  = st_one[s] ? (st_msk_q[s] & st_pl[s]) : st_zero[s];
      nx_rank[s] = st_one[s] ? st_rank_q[s] - st_cnt[s] : st_rank_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PixBits; s++) st_vld_q[s] <= 1'b0;
    end else begin
      st_vld_q[0] <= s1_vld_q && s1_out_q;
      for (int s = 1; s < PixBits; s++) st_vld_q[s] <= st_vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_val_q[0]  <= win;
    st_msk_q[0]  <= win_msk;
    st_rank_q[0] <= median_rank(s1_w_q);
    st_res_q[0]  <= '0;
    st_meta_q[0] <= s1_meta_q;
    for (int s = 1; s < PixBits; s++) begin
      st_val_q[s]  <= st_val_q[s-1];
      st_msk_q[s]  <= nx_msk[s-1];
      st_rank_q[s] <= nx_rank[s-1];
      st_res_q[s]  <= nx_res[s-1];
      st_meta_q[s] <= st_meta_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Result FIFO; input requests reserve a slot so the pipeline never stalls
  // ---------------------------------------------------------------------------
  res_t                  fifo_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrBits:0]   fcnt_q;
  logic                   push, pop;
  res_t                   push_item, head;

  always_comb begin
    push = st_vld_q[PixBits-1];
    pop  = res_o.valid && res_o.ready;
    push_item = '{value: st_meta_q[PixBits-1].inner ? nx_res[PixBits-1] : White,
                  row:   st_meta_q[PixBits-1].row,
                  col:   st_meta_q[PixBits-1].col,
                  last:  st_meta_q[PixBits-1].last};
    head = fifo_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      resv_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FifoPtrBits'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FifoPtrBits'(1);
      fcnt_q <= fcnt_q + (FifoPtrBits+1)'(push) - (FifoPtrBits+1)'(pop);
      resv_q <= resv_q + (FifoPtrBits+1)'(acc && out_vld) - (FifoPtrBits+1)'(pop);
    end
  end

  assign res_o.valid   = (fcnt_q != '0);
  assign res_o.value   = head.value;
  assign res_o.out_row = head.row;
  assign res_o.out_col = head.col;
  assign res_o.last    = head.last;

endmodule

// ===== src/mf2d_checker.sv =====
// Port-level checker of the 2-D median filter and its bind to the top level.
`timescale 1ns / 1ps

module mf2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] out_data_i
);

  // hold input off while the line store is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_ready_i)
    else $error("input ready right after reset");

  // a configuration write starts the position re-division
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("input ready right after configuration write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind median_filter_2d_core mf2d_checker u_mf2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  ({res_o.value, res_o.out_row, res_o.out_col, res_o.last})
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the streaming 2-D median filter core.
`timescale 1ns / 1ps

module tb_top;
  import mf2d_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 40;   // settles the pipeline after the last expected result

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0] cfg_data_i = '0;

  mf2d_pix_if pix_if ();
  mf2d_res_if res_if ();

  median_filter_2d_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the core: line store, input position and register values.
  pix_t           shadow_lines [MaxWindow*MaxCols];
  int unsigned    shadow_pos;
  int unsigned    reg_window, reg_cols, reg_rows;
  res_t           pending_medians [$];

  int unsigned    n_requests, n_results, n_frames, n_errors, cycle_count;
  bit             no_idle;    // suppress random gaps on both sides
  bit             hold_req;   // ask the receiver for one long hold-off

  // Apply one accepted request to the shadow and queue the result it causes.
  function automatic void predict_median(input pix_t pixel, input logic frame_start);
    int unsigned w, cols, rows, n1, after, total, delay, q, p, r, c;
    int vals [$];
    res_t exp_res;
    w     = (reg_window == 0) ? 1 : reg_window;
    cols  = (reg_cols == 0) ? 1 : (reg_cols > MaxCols ? MaxCols : reg_cols);
    rows  = (reg_rows == 0) ? 1 : (reg_rows > MaxRows ? MaxRows : reg_rows);
    n1    = (w - 1) / 2;
    after = w / 2;
    total = rows * cols;
    delay = after * (cols + 1);
    if (frame_start) shadow_pos = 0;
    q = shadow_pos;
    if (q < total) shadow_lines[((q / cols) % MaxWindow) * MaxCols + q % cols] = pixel;
    if (q >= delay && q - delay < total) begin
      p = q - delay;
      r = p / cols;
      c = p % cols;
      exp_res.value = '1;
      if (r >= n1 && r + after < rows && c >= n1 && c + after < cols) begin
        for (int i = 0; i < w; i++)
          for (int j = 0; j < w; j++)
            vals.push_back(shadow_lines[((r - n1 + i) % MaxWindow) * MaxCols + c - n1 + j]);
        vals.sort();
        exp_res.value = pix_t'(vals[(w * w - 1) / 2]);
      end
      exp_res.row  = OutRowBits'(r);
      exp_res.col  = ColBits'(c);
      exp_res.last = (p == total - 1);
      pending_medians.push_back(exp_res);
    end
    if (shadow_pos < 32'h7FFFFF) shadow_pos++;
  endfunction

  // Sender: drive one request, hold it until accepted, then maybe idle.
  task automatic send_pixel(input pix_t pixel, input logic frame_start);
    pix_if.valid       <= 1'b1;
    pix_if.pixel       <= pixel;
    pix_if.frame_start <= frame_start;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    predict_median(pixel, frame_start);
    n_requests++;
    if (!no_idle && $urandom_range(99) < 22) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // Wait until every expected result is in, then let the pipeline settle.
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgBits'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgWindow: reg_window = data & 32'h7;
      CfgCols:   reg_cols   = data & 32'h7FF;
      CfgRows:   reg_rows   = data & 32'h1FFF;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned cols,
                           input int unsigned rows);
    drain();
    write_reg(CfgWindow, w);
    write_reg(CfgCols, cols);
    write_reg(CfgRows, rows);
  endtask

  // Send one frame plus the fillers that flush it. Mode: 0 random, 1 black,
  // 2 white, 3 black/white checker. cut > 0 aborts the frame after cut pixels;
  // pause_at > 0 makes the sender wait there for all results.
  task automatic run_frame(input int mode, input int unsigned cut, input int unsigned pause_at);
    int unsigned w, cols, rows, total, count;
    pix_t px;
    w     = (reg_window == 0) ? 1 : reg_window;
    cols  = (reg_cols == 0) ? 1 : (reg_cols > MaxCols ? MaxCols : reg_cols);
    rows  = (reg_rows == 0) ? 1 : (reg_rows > MaxRows ? MaxRows : reg_rows);
    total = rows * cols;
    count = (cut != 0) ? cut : total + (w / 2) * (cols + 1) + $urandom_range(2);
    for (int unsigned i = 0; i < count; i++) begin
      case (mode)
        1:       px = '0;
        2:       px = '1;
        3:       px = (i[0] ^ (i / cols) % 2) ? '1 : '0;
        default: px = pix_t'($urandom);
      endcase
      if (pause_at != 0 && i == pause_at) begin
        pix_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_medians.size() != 0) @(posedge clk_i);
      end
      send_pixel(px, i == 0);
    end
    n_frames++;
  endtask

  // Results: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected result value=%0d row=%0d col=%0d last=%0b", $time,
                 res_if.value, res_if.out_row, res_if.out_col, res_if.last);
        n_errors++;
      end else begin
        res_t exp_res;
        exp_res = pending_medians.pop_front();
        n_results++;
        if (res_if.value !== exp_res.value) begin
          $display("%0t: value expected %0d actual %0d", $time, exp_res.value, res_if.value);
          n_errors++;
        end
        if (res_if.out_row !== exp_res.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, res_if.out_row);
          n_errors++;
        end
        if (res_if.out_col !== exp_res.col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, res_if.out_col);
          n_errors++;
        end
        if (res_if.last !== exp_res.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_res.last, res_if.last);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 22);
      end
    end
  end

  // Watchdog: give up after a generous number of cycles.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_medians.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Stream before any frame start, at the reset sizes: nothing comes out yet.
  task automatic test_before_frame();
    for (int i = 0; i < 3; i++) send_pixel(pix_t'($urandom), 1'b0);
  endtask

  // Directed: pixel extremes, odd and even windows, window larger than the
  // image, and registers at zero.
  task automatic test_directed();
    configure(3, 3, 3);
    run_frame(1, 0, 0);
    configure(2, 2, 2);
    run_frame(2, 0, 0);
    configure(0, 0, 0);
    run_frame(3, 0, 0);
    configure(7, 2, 2);
    run_frame(0, 0, 0);
  endtask

  // Random frames: mostly well-formed, some aborted by an early frame start,
  // a few with a sender pause waiting for every result.
  task automatic test_random_frames();
    int unsigned start;
    start = n_requests;
    no_idle = 1'b1;
    while (n_requests - start < 650) begin
      if (n_requests - start > 200) no_idle = 1'b0;
      configure($urandom_range(7), $urandom_range(12, 1), $urandom_range(10, 1));
      if ($urandom_range(99) < 15)
        run_frame($urandom_range(3), $urandom_range(20, 1), 0);
      else
        run_frame($urandom_range(9) < 8 ? 0 : $urandom_range(3), 0,
                  $urandom_range(9) == 0 ? $urandom_range(10, 1) : 0);
    end
    no_idle = 1'b0;
  endtask

  // Long receiver hold-off while the sender keeps streaming.
  task automatic test_backpressure();
    configure(5, 8, 8);
    hold_req = 1'b1;
    run_frame(0, 0, 0);
  endtask

  // Registers past their limits: the widest row and the tallest column,
  // each frame cut short after its first pixels.
  task automatic test_largest();
    configure(1, 2047, 3);
    run_frame(0, 60, 0);
    configure(1, 1, 8191);
    run_frame(0, 60, 0);
  endtask

  initial begin
    pix_if.valid       <= 1'b0;
    pix_if.pixel       <= '0;
    pix_if.frame_start <= 1'b0;
    foreach (shadow_lines[i]) shadow_lines[i] = '0;
    shadow_pos = 0;
    reg_window = 3;
    reg_cols   = 640;
    reg_rows   = 480;
    n_requests = 0;
    n_results  = 0;
    n_frames   = 0;
    n_errors   = 0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_before_frame();
    test_directed();
    test_backpressure();
    test_random_frames();
    test_largest();

    drain();
    $display("covered %0d pixel requests in %0d frames, windows 0..7, registers past limits",
             n_requests, n_frames);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== median_filter_2d_core.f =====
src/mf2d_pkg.sv
src/mf2d_if.sv
src/median_filter_2d_core.sv
src/mf2d_checker.sv
tb/tb_top.sv
